// ----- src/assert_macros.svh -----
// Assertion macros for the sliding-window RMS block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define SWR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swrms: same-cycle check failed");

// Antecedent implies consequent in the following cycle
`define SWR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swrms: next-cycle check failed");

`endif

// ----- src/swrms_pkg.sv -----
// Shared types, widths and helpers of the sliding-window RMS block
package swrms_pkg;
	localparam int DATA_W            = 16;
	localparam int ROOT_W            = 16;
	localparam int SQ_W              = 2 * DATA_W - 1;
	localparam int NUM_CH            = 3;
	localparam int CH_W              = 2;
	localparam int WINDOW_LENGTH_DEF = 50;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [ROOT_W-1:0]        root_t;
	typedef logic [SQ_W-1:0]          square_t;

	// Status of the iterative root unit
	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

	// Width of an exact sum of squares over a window of the given depth
	function automatic int sum_width(input int depth);
		return SQ_W + $clog2(depth);
	endfunction

	// Square of a signed sample, exact
	function automatic square_t square_mag(input sample_t v);
		logic [DATA_W-1:0]   mag;
		logic [2*DATA_W-1:0] prod;
		mag  = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
		prod = mag * mag;
		return prod[SQ_W-1:0];
	endfunction
endpackage

// ----- src/swrms_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module swrms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

// ----- src/swrms_sqrt.sv -----
// Iterative root unit: floor(sqrt(operand / WINDOW_LENGTH)), one result bit per cycle
module swrms_sqrt #(
	parameter int WINDOW_LENGTH = swrms_pkg::WINDOW_LENGTH_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 start,
	input  logic [swrms_pkg::sum_width(WINDOW_LENGTH)-1:0]       operand,
	output swrms_pkg::root_t                                     root,
	output swrms_pkg::sqrt_stat_t                                stat
);
	import swrms_pkg::*;

	localparam int SUM_W = sum_width(WINDOW_LENGTH);
	localparam int AW    = SUM_W + 2;
	localparam logic [AW-1:0] STEP_INIT = AW'(WINDOW_LENGTH) << (2 * (ROOT_W - 1));

	// acc = r*r*W, part = r*W*2^(b+1), step = W*2^(2b) for current bit b
	logic [AW-1:0]     acc_q;
	logic [AW-1:0]     part_q;
	logic [AW-1:0]     step_q;
	logic [AW-1:0]     trial;
	logic [ROOT_W-1:0] mask_q;
	root_t             root_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	// Trial square of the root with the current bit set, scaled by the window length
	assign trial = acc_q + part_q + step_q;
	assign fits  = trial <= AW'(operand);

	// Track busy and raise done for one cycle after the last bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && mask_q[0];
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && mask_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Decide one root bit per cycle, most significant first
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			part_q <= '0;
			step_q <= STEP_INIT;
			mask_q <= {1'b1, {(ROOT_W-1){1'b0}}};
			root_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				acc_q  <= trial;
				part_q <= (part_q >> 1) + step_q;
				root_q <= root_q | mask_q;
			end else begin
				part_q <= part_q >> 1;
			end
			step_q <= step_q >> 2;
			mask_q <= mask_q >> 1;
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

// ----- src/sliding_window_rms_three_channel.sv -----
// Top level of the three-channel sliding-window RMS block.
// Input channel (in_valid/in_ready) takes one frame: new_valid plus left, right
// and total divergence, signed Q4.12. When new_valid is set the three values
// replace the slot under the slot pointer; the pointer advances on every frame.
// Output channel (out_valid/out_ready) returns one transaction per frame: the
// RMS over all WINDOW_LENGTH slots of each window, unsigned Q4.12, truncated.
// Each frame passes through a RAM read of the slot, a sum update through one
// shared squarer (skipped when no new values are stored), and then, channel by
// channel, the shared bit-serial root unit, which yields 16 result bits, before
// the output register is loaded.
// The block takes one frame at a time; in_ready is high only when idle, so a new
// frame is taken only once the last result is in the output register.
// A finished result waits in the output register, so the next frame may be
// accepted while the receiver stalls; a further result then holds until the
// output register is taken.
// Reset clears the slot pointer, the running sums and a valid bit per slot;
// slots not yet written read as zero, so no clearing pass is needed.
`include "assert_macros.svh"

module sliding_window_rms_three_channel #(
	parameter int WINDOW_LENGTH = swrms_pkg::WINDOW_LENGTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                new_valid,
	input  swrms_pkg::sample_t  left_div,
	input  swrms_pkg::sample_t  right_div,
	input  swrms_pkg::sample_t  total_div,
	output logic                out_valid,
	input  logic                out_ready,
	output swrms_pkg::root_t    left_rms,
	output swrms_pkg::root_t    right_rms,
	output swrms_pkg::root_t    total_rms
);
	import swrms_pkg::*;

	localparam int PTR_W  = $clog2(WINDOW_LENGTH);
	localparam int SUM_W  = sum_width(WINDOW_LENGTH);
	localparam int SLOT_W = NUM_CH * DATA_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_ROOT = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	// Sub-steps of the sum update and of the root phase
	localparam logic [1:0] P_OLD   = 2'd0;
	localparam logic [1:0] P_NEW   = 2'd1;
	localparam logic [1:0] P_ADD   = 2'd2;
	localparam logic [1:0] R_START = 2'd0;
	localparam logic [1:0] R_WAIT  = 2'd1;

	localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);

	logic [2:0]               state_q;
	logic [CH_W-1:0]          ch_q;
	logic [1:0]               phase_q;
	logic [PTR_W-1:0]         ptr_q;
	logic [WINDOW_LENGTH-1:0] slot_valid_q;
	logic                     store_q;
	sample_t                  new_q [NUM_CH];
	sample_t                  old_q [NUM_CH];
	square_t                  sq_q;
	logic [SUM_W-1:0]         sum_q [NUM_CH];
	root_t                    root_q [NUM_CH];
	root_t                    left_rms_q;
	root_t                    right_rms_q;
	root_t                    total_rms_q;
	logic                     out_valid_q;

	logic                     accept;
	logic                     out_load;
	logic                     ram_wr_en;
	logic [SLOT_W-1:0]        ram_wr_data;
	logic [SLOT_W-1:0]        ram_rd_data;
	sample_t                  mul_in;
	logic                     sqrt_start;
	root_t                    sqrt_root;
	sqrt_stat_t               sqrt_stat;

	assign in_ready  = state_q == S_IDLE;
	assign accept    = in_valid && in_ready;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign ram_wr_en = (state_q == S_READ) && store_q;
	assign ram_wr_data = {new_q[2], new_q[1], new_q[0]};
	assign mul_in    = (phase_q == P_OLD) ? old_q[ch_q] : new_q[ch_q];
	assign sqrt_start = (state_q == S_ROOT) && (phase_q == R_START);

	// Window storage, one row of three samples per slot
	swrms_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (WINDOW_LENGTH)
	) u_window (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ptr_q),
		.wr_data (ram_wr_data),
		.rd_addr (ptr_q),
		.rd_data (ram_rd_data)
	);

	// Shared root unit for the three channels
	swrms_sqrt #(
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.operand (sum_q[ch_q]),
		.root    (sqrt_root),
		.stat    (sqrt_stat)
	);

	// Sequence the frame: read slot, update sums, take roots, hand off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ch_q         <= '0;
			phase_q      <= P_OLD;
			ptr_q        <= '0;
			slot_valid_q <= '0;
			for (int c = 0; c < NUM_CH; c++) begin
				sum_q[c] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// write the new row, if there is one, and advance the pointer
					if (store_q) begin
						slot_valid_q[ptr_q] <= 1'b1;
					end
					ptr_q   <= (ptr_q == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : ptr_q + 1'b1;
					ch_q    <= '0;
					phase_q <= P_OLD;
					state_q <= store_q ? S_UPD : S_ROOT;
				end
				S_UPD: begin
					case (phase_q)
						P_OLD: phase_q <= P_NEW;
						P_NEW: begin
							sum_q[ch_q] <= sum_q[ch_q] - SUM_W'(sq_q);
							phase_q     <= P_ADD;
						end
						default: begin
							sum_q[ch_q] <= sum_q[ch_q] + SUM_W'(sq_q);
							if (ch_q == CH_LAST) begin
								ch_q    <= '0;
								phase_q <= R_START;
								state_q <= S_ROOT;
							end else begin
								ch_q    <= ch_q + 1'b1;
								phase_q <= P_OLD;
							end
						end
					endcase
				end
				S_ROOT: begin
					if (phase_q == R_START) begin
						phase_q <= R_WAIT;
					end else if (sqrt_stat.done) begin
						phase_q <= R_START;
						if (ch_q == CH_LAST) begin
							state_q <= S_FIN;
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the frame, the old row, the square and the roots
	always_ff @(posedge clk) begin
		if (accept) begin
			store_q  <= new_valid;
			new_q[0] <= left_div;
			new_q[1] <= right_div;
			new_q[2] <= total_div;
		end
		if (state_q == S_READ) begin
			for (int c = 0; c < NUM_CH; c++) begin
				old_q[c] <= slot_valid_q[ptr_q] ? sample_t'(ram_rd_data[c*DATA_W +: DATA_W])
				                                : '0;
			end
		end
		if (state_q == S_UPD) begin
			sq_q <= square_mag(mul_in);
		end
		if ((state_q == S_ROOT) && (phase_q == R_WAIT) && sqrt_stat.done) begin
			root_q[ch_q] <= sqrt_root;
		end
		if (out_load) begin
			left_rms_q  <= root_q[0];
			right_rms_q <= root_q[1];
			total_rms_q <= root_q[2];
		end
	end

	// Output register valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign left_rms  = left_rms_q;
	assign right_rms = right_rms_q;
	assign total_rms = total_rms_q;

	`SWR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !in_ready)
	`SWR_ASSERT_IMPL(a_root_unit_free, clk, arst_n, sqrt_start, !sqrt_stat.busy)
	`SWR_ASSERT_IMPL(a_load_when_free, clk, arst_n, out_load, !out_valid_q || out_ready)
	`SWR_ASSERT_IMPL(a_ptr_in_range, clk, arst_n, 1'b1, ptr_q <= PTR_W'(WINDOW_LENGTH - 1))
endmodule

// ----- verif/tb_sliding_window_rms_three_channel.sv -----
// Self-checking testbench for the three-channel sliding-window RMS block
`timescale 1ns / 1ps

module tb_sliding_window_rms_three_channel;
	import swrms_pkg::*;

	localparam int WIN       = WINDOW_LENGTH_DEF;
	localparam int LONG_HOLD = 600;
	localparam int N_DIRECT  = 12;

	typedef struct {
		root_t left;
		root_t right;
		root_t total;
	} rms_triple_t;

	typedef struct {
		bit      nv;
		sample_t l;
		sample_t r;
		sample_t t;
		bit      typed;
		root_t   el;
		root_t   er;
		root_t   et;
	} frame_row_t;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	logic    new_valid;
	sample_t left_div;
	sample_t right_div;
	sample_t total_div;
	logic    out_valid;
	logic    out_ready;
	root_t   left_rms;
	root_t   right_rms;
	root_t   total_rms;

	// Predictor copy of the three windows and the slot pointer
	sample_t div_window [NUM_CH][WIN];
	int      slot_idx;

	rms_triple_t pending_rms [$];

	int tx_idle_pct;
	int rx_idle_pct;
	bit long_hold_req;

	int frames_sent;
	int frames_skipped;
	int results_checked;
	int full_scale_hits;
	int mismatches;

	// Hand-checked rows first (typed where the answer is obvious), then predictor rows
	frame_row_t frame_rows [N_DIRECT] = '{
		'{1'b0, 16'h7FFF, 16'h8000, 16'h1234, 1'b1, 16'd0, 16'd0, 16'd0},
		'{1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'd0, 16'd0, 16'd0},
		'{1'b1, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, 16'd0, 16'd0, 16'd0},
		'{1'b1, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 16'd0, 16'd0, 16'd0},
		'{1'b0, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'd0, 16'd0, 16'd0},
		'{1'b1, 16'h0001, 16'hFFFF, 16'h8000, 1'b0, 16'd0, 16'd0, 16'd0},
		'{1'b1, 16'h5555, 16'hAAAA, 16'h7FFF, 1'b0, 16'd0, 16'd0, 16'd0},
		'{1'b1, 16'hAAAA, 16'h5555, 16'h0001, 1'b0, 16'd0, 16'd0, 16'd0},
		'{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0, 16'd0, 16'd0},
		'{1'b1, 16'h1000, 16'hF000, 16'h2000, 1'b0, 16'd0, 16'd0, 16'd0},
		'{1'b1, 16'h00FF, 16'hFF00, 16'h0F0F, 1'b0, 16'd0, 16'd0, 16'd0},
		'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0, 16'd0}
	};

	sliding_window_rms_three_channel DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.new_valid (new_valid),
		.left_div  (left_div),
		.right_div (right_div),
		.total_div (total_div),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.left_rms  (left_rms),
		.right_rms (right_rms),
		.total_rms (total_rms)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Truncated square root, built one result bit at a time from the top
	function automatic root_t floor_sqrt(input longint unsigned q);
		longint unsigned acc;
		longint unsigned trial;
		acc = 0;
		for (int b = 16; b >= 0; b--) begin
			trial = acc | (64'd1 << b);
			if (trial * trial <= q)
				acc = trial;
		end
		return root_t'(acc);
	endfunction

	// Apply one frame to the windows and return the RMS of each full window
	function automatic rms_triple_t frame_rms(input bit nv, input sample_t l,
			input sample_t r, input sample_t t);
		longint          v;
		longint unsigned sq_sum [NUM_CH];
		root_t           roots [NUM_CH];
		rms_triple_t     res;
		if (nv) begin
			div_window[0][slot_idx] = l;
			div_window[1][slot_idx] = r;
			div_window[2][slot_idx] = t;
		end
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sq_sum[ch] = 0;
			for (int i = 0; i < WIN; i++) begin
				v = div_window[ch][i];
				sq_sum[ch] += longint'(unsigned'(v * v));
			end
			roots[ch] = floor_sqrt(sq_sum[ch] / WIN);
		end
		slot_idx  = (slot_idx == WIN - 1) ? 0 : slot_idx + 1;
		res.left  = roots[0];
		res.right = roots[1];
		res.total = roots[2];
		return res;
	endfunction

	// Offer one frame, hold it until accepted, then queue its expected RMS
	task automatic offer_frame(input frame_row_t row);
		int          gap;
		rms_triple_t predicted;
		gap = 0;
		if ($urandom_range(99) < tx_idle_pct)
			gap = ($urandom_range(3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		new_valid <= row.nv;
		left_div  <= row.l;
		right_div <= row.r;
		total_div <= row.t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = frame_rms(row.nv, row.l, row.r, row.t);
		if (row.typed) begin
			predicted.left  = row.el;
			predicted.right = row.er;
			predicted.total = row.et;
		end
		pending_rms.push_back(predicted);
		frames_sent++;
		if (!row.nv)
			frames_skipped++;
	endtask

	// Stop offering and wait until every queued result has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_rms.size() != 0)
			@(posedge clk);
	endtask

	// Random frames in runs: noise, extreme fills, small values, skipped frames
	task automatic run_random(input int n_frames);
		int         sent;
		int         kind;
		int         run_len;
		frame_row_t row;
		sent = 0;
		while (sent < n_frames) begin
			kind    = $urandom_range(5);
			run_len = (kind == 1 || kind == 2) ? $urandom_range(50, 56) : $urandom_range(1, 40);
			for (int k = 0; k < run_len && sent < n_frames; k++) begin
				row.typed = 1'b0;
				row.el    = '0;
				row.er    = '0;
				row.et    = '0;
				case (kind)
					1: begin
						row.nv = 1'b1;
						row.l  = 16'h8000;
						row.r  = 16'h8000;
						row.t  = 16'h8000;
					end
					2: begin
						row.nv = 1'b1;
						row.l  = 16'h7FFF;
						row.r  = 16'h8000;
						row.t  = 16'h7FFF;
					end
					3: begin
						row.nv = ($urandom_range(9) != 0);
						row.l  = sample_t'($urandom_range(127)) - sample_t'(64);
						row.r  = sample_t'($urandom_range(127)) - sample_t'(64);
						row.t  = sample_t'($urandom_range(127)) - sample_t'(64);
					end
					4: begin
						row.nv = ($urandom_range(4) == 0);
						row.l  = sample_t'($urandom_range(65535));
						row.r  = sample_t'($urandom_range(65535));
						row.t  = sample_t'($urandom_range(65535));
					end
					5: begin
						row.nv = ($urandom_range(5) != 0);
						row.l  = ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
						row.r  = ($urandom_range(1)) ? 16'hFFFF : 16'h0001;
						row.t  = ($urandom_range(1)) ? 16'h8000 : 16'h0000;
					end
					default: begin
						row.nv = ($urandom_range(4) != 0);
						row.l  = sample_t'($urandom_range(65535));
						row.r  = sample_t'($urandom_range(65535));
						row.t  = sample_t'($urandom_range(65535));
					end
				endcase
				offer_frame(row);
				sent++;
			end
		end
	endtask

	// Receiver: random stalls with occasional stretches, plus one long hold-off on request
	initial begin
		int hold_cnt;
		hold_cnt  = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if ($urandom_range(99) < rx_idle_pct) begin
				out_ready <= 1'b0;
				hold_cnt = ($urandom_range(9) == 0) ? $urandom_range(5, 60) : 0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Check each result transaction against the oldest expectation
	always @(posedge clk) begin
		rms_triple_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rms.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected result %0d %0d %0d", left_rms, right_rms,
						total_rms);
			end else begin
				want = pending_rms.pop_front();
				results_checked++;
				if (left_rms == 16'h8000 || right_rms == 16'h8000 || total_rms == 16'h8000)
					full_scale_hits++;
				if (left_rms !== want.left || right_rms !== want.right
						|| total_rms !== want.total) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: rms mismatch exp %0d %0d %0d got %0d %0d %0d",
							want.left, want.right, want.total,
							left_rms, right_rms, total_rms);
				end
			end
		end
	end

	// Hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		new_valid       = 1'b0;
		left_div        = '0;
		right_div       = '0;
		total_div       = '0;
		long_hold_req   = 1'b0;
		tx_idle_pct     = 31;
		rx_idle_pct     = 67;
		frames_sent     = 0;
		frames_skipped  = 0;
		results_checked = 0;
		full_scale_hits = 0;
		mismatches      = 0;
		slot_idx        = 0;
		for (int ch = 0; ch < NUM_CH; ch++)
			for (int i = 0; i < WIN; i++)
				div_window[ch][i] = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames: reset state, extremes, skipped frames
		for (int i = 0; i < N_DIRECT; i++)
			offer_frame(frame_rows[i]);

		// Sender slow, receiver slower; fill the block behind a long receiver hold-off
		run_random(60);
		long_hold_req = 1'b1;
		run_random(80);
		drain_results();
		run_random(60);

		// Roles swapped
		tx_idle_pct = 67;
		rx_idle_pct = 31;
		run_random(200);

		// Full rate, with one more sender pause and receiver hold-off
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(100);
		drain_results();
		long_hold_req = 1'b1;
		run_random(100);

		drain_results();
		repeat (200) @(posedge clk);
		mismatches += pending_rms.size();

		$display("tb: %0d frames sent, %0d of them without new values, %0d results checked",
			frames_sent, frames_skipped, results_checked);
		$display("tb: full-scale RMS seen %0d times, %0d mismatches", full_scale_hits,
			mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
